FILE: rtl/wrr_pkg.sv
// Weighted round-robin pass scheduler: shared types and constants.
// No dependencies; compiled first.
package wrr_pkg;

  localparam int QIDX_BITS       = 3;
  localparam int NUM_WEIGHT_REGS = 4;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_AUTO_ADD = 3'd4;

  typedef enum logic {
    OP_ENQUEUE,
    OP_PASS
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       target_ok;
    logic [1:0] qidx;
  } cmd_t;

  typedef struct packed {
    logic       grant_valid;
    logic [1:0] granted_queue;
    logic       enqueue_accepted;
    logic       credits_reloaded;
    logic       all_empty;
    logic       last;
  } result_t;

endpackage

FILE: rtl/wrr_if.sv
// Request and result channel interfaces (valid/ready with payload).
// No dependencies.
interface wrr_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [1:0] queue_index;

  modport source(output valid, func, queue_index, input ready);
  modport sink(input valid, func, queue_index, output ready);
endinterface

interface wrr_res_if;
  logic       valid;
  logic       ready;
  logic       grant_valid;
  logic [1:0] granted_queue;
  logic       enqueue_accepted;
  logic       credits_reloaded;
  logic       all_empty;
  logic       last;

  modport source(output valid, grant_valid, granted_queue, enqueue_accepted,
                 credits_reloaded, all_empty, last, input ready);
  modport sink(input valid, grant_valid, granted_queue, enqueue_accepted,
               credits_reloaded, all_empty, last, output ready);
endinterface

FILE: rtl/wrr_front.sv
// Front stage: takes requests, classifies them into commands, registers them.
// Depends on wrr_pkg and wrr_req_if.
module wrr_front #(
  parameter int NUM_QUEUES = 4
) (
  input  logic          clk,
  input  logic          rst,
  wrr_req_if.sink       req,
  output logic          push_valid,
  input  logic          push_ready,
  output wrr_pkg::cmd_t push_cmd
);
  import wrr_pkg::*;

  logic stage_valid;
  cmd_t stage_cmd;
  logic take;

  assign req.ready  = !stage_valid || push_ready;
  assign take       = req.valid && req.ready;
  assign push_valid = stage_valid;
  assign push_cmd   = stage_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_cmd.op        <= req.func ? OP_PASS : OP_ENQUEUE;
      stage_cmd.target_ok <= (32'(req.queue_index) < NUM_QUEUES);
      stage_cmd.qidx      <= req.queue_index;
    end
  end

endmodule

FILE: rtl/wrr_cmd_fifo.sv
// Two-entry command queue between front and back.
// Depends on wrr_pkg.
module wrr_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  wrr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output wrr_pkg::cmd_t pop_cmd
);
  import wrr_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_cmd;
  end

endmodule

FILE: rtl/wrr_back.sv
// Back end: queue counts, credits, weights; executes commands and emits results.
// Depends on wrr_pkg and wrr_res_if.
module wrr_back #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 256,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wrr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wrr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  wrr_pkg::cmd_t                      cmd,
  wrr_res_if.source                          res
);
  import wrr_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int WR = (NUM_QUEUES < NUM_WEIGHT_REGS) ? NUM_QUEUES : NUM_WEIGHT_REGS;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic [WEIGHT_BITS-1:0] weight_reg [WR];
  logic [WEIGHT_BITS-1:0] weight     [NUM_QUEUES];
  logic                   auto_add;

  logic [CW-1:0]          pend       [NUM_QUEUES];
  logic [CW-1:0]          pend_next  [NUM_QUEUES];
  logic [WEIGHT_BITS-1:0] cred       [NUM_QUEUES];
  logic [WEIGHT_BITS-1:0] cred_next  [NUM_QUEUES];

  logic [CW-1:0]          pend_dec   [NUM_QUEUES];
  logic [CW-1:0]          pend_pass  [NUM_QUEUES];
  logic [WEIGHT_BITS-1:0] cred_dec   [NUM_QUEUES];
  logic [WEIGHT_BITS-1:0] cred_pass  [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]  grant;
  logic [NUM_QUEUES-1:0]  hit;
  logic                   any_pend;
  logic                   any_cred;
  logic                   reload;
  logic                   accepted;

  logic                   busy, busy_next;
  logic [NUM_QUEUES-1:0]  mask, mask_next;
  logic                   hold_rel, hold_rel_next;
  logic                   hold_emp, hold_emp_next;
  result_t                out_q, out_next;
  logic                   out_valid, out_valid_next;

  logic                   advance;
  logic                   take;
  logic                   emit_grant;
  logic [NUM_QUEUES-1:0]  src_mask;
  logic [NUM_QUEUES-1:0]  rest;
  logic                   src_rel;
  logic                   src_emp;
  logic [QIDX_BITS-1:0]   idx;

  // configuration
  for (genvar gw = 0; gw < WR; gw++) begin : g_wreg
    always_ff @(posedge clk) begin
      if (rst) begin
        weight_reg[gw] <= WEIGHT_BITS'(1);
      end else if (cfg_we && cfg_index == CFG_INDEX_BITS'(gw)) begin
        weight_reg[gw] <= WEIGHT_BITS'(cfg_data);
      end
    end
  end

  for (genvar gq = 0; gq < NUM_QUEUES; gq++) begin : g_weight
    if (gq < WR) begin : g_cfg
      assign weight[gq] = weight_reg[gq];
    end else begin : g_fixed
      assign weight[gq] = WEIGHT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_add <= 1'b0;
    end else if (cfg_we && cfg_index == REG_AUTO_ADD) begin
      auto_add <= cfg_data[0];
    end
  end

  // per-queue pass and enqueue terms
  always_comb begin
    any_pend = 1'b0;
    any_cred = 1'b0;
    accepted = 1'b0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      grant[q]    = (pend[q] != '0) && (cred[q] != '0);
      pend_dec[q] = pend[q] - CW'(grant[q]);
      cred_dec[q] = cred[q] - WEIGHT_BITS'(grant[q]);
      if (pend_dec[q] != '0) any_pend = 1'b1;
      if (cred_dec[q] != '0) any_cred = 1'b1;
      hit[q] = cmd.target_ok && ({1'b0, cmd.qidx} == QIDX_BITS'(q));
      if (hit[q] && pend[q] < DEPTH_C) accepted = 1'b1;
    end
    reload = any_pend && !any_cred;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      pend_pass[q] = pend_dec[q] +
                     CW'(auto_add && any_pend && (pend_dec[q] < DEPTH_C));
      cred_pass[q] = reload ? weight[q] : cred_dec[q];
    end
  end

  // lowest pending grant
  always_comb begin
    idx = '0;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      if (src_mask[q]) idx = QIDX_BITS'(q);
    end
  end
  assign rest = src_mask & (src_mask - NUM_QUEUES'(1));

  assign advance   = !out_valid || res.ready;
  assign cmd_ready = advance && !busy;
  assign take      = cmd_valid && cmd_ready;

  always_comb begin
    pend_next      = pend;
    cred_next      = cred;
    busy_next      = busy;
    mask_next      = mask;
    hold_rel_next  = hold_rel;
    hold_emp_next  = hold_emp;
    out_next       = out_q;
    out_valid_next = out_valid && !res.ready;
    src_mask       = mask;
    src_rel        = hold_rel;
    src_emp        = hold_emp;
    emit_grant     = 1'b0;

    if (busy && advance) begin
      emit_grant = 1'b1;
    end else if (take) begin
      unique case (cmd.op)
        OP_ENQUEUE: begin
          for (int q = 0; q < NUM_QUEUES; q++) begin
            if (hit[q] && pend[q] < DEPTH_C) pend_next[q] = pend[q] + CW'(1);
          end
          out_next = '{grant_valid: 1'b0, granted_queue: 2'd0,
                       enqueue_accepted: accepted, credits_reloaded: 1'b0,
                       all_empty: 1'b0, last: 1'b1};
          out_valid_next = 1'b1;
        end
        OP_PASS: begin
          pend_next = pend_pass;
          cred_next = cred_pass;
          if (grant == '0) begin
            out_next = '{grant_valid: 1'b0, granted_queue: 2'd0,
                         enqueue_accepted: 1'b0, credits_reloaded: reload,
                         all_empty: !any_pend, last: 1'b1};
            out_valid_next = 1'b1;
          end else begin
            src_mask   = grant;
            src_rel    = reload;
            src_emp    = !any_pend;
            emit_grant = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (emit_grant) begin
      out_next = '{grant_valid: 1'b1, granted_queue: idx[1:0],
                   enqueue_accepted: 1'b0,
                   credits_reloaded: (rest == '0) && src_rel,
                   all_empty: (rest == '0) && src_emp,
                   last: (rest == '0)};
      out_valid_next = 1'b1;
      mask_next      = rest;
      busy_next      = (rest != '0);
      hold_rel_next  = src_rel;
      hold_emp_next  = src_emp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        pend[q] <= '0;
        cred[q] <= WEIGHT_BITS'(1);
      end
      busy      <= 1'b0;
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      pend      <= pend_next;
      cred      <= cred_next;
      busy      <= busy_next;
      mask      <= mask_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_q    <= out_next;
    hold_rel <= hold_rel_next;
    hold_emp <= hold_emp_next;
  end

  assign res.valid            = out_valid;
  assign res.grant_valid      = out_q.grant_valid;
  assign res.granted_queue    = out_q.granted_queue;
  assign res.enqueue_accepted = out_q.enqueue_accepted;
  assign res.credits_reloaded = out_q.credits_reloaded;
  assign res.all_empty        = out_q.all_empty;
  assign res.last             = out_q.last;

endmodule

FILE: rtl/weighted_round_robin_pass.sv
// Weighted round-robin pass scheduler, top level.
// Depends on wrr_pkg, wrr_if, wrr_front, wrr_cmd_fifo, wrr_back.
//
//   port     dir   kind           carries
//   req_ch   in    valid/ready    func, queue_index
//   res_ch   out   valid/ready    grant_valid .. last
//   cfg_*    in    write enable   weight_q0..q3, auto_add
//
// Enqueue: one result. Pass: one per granted queue, or one if none is granted;
// one result per cycle while res_ch is ready, set by the single result
// register. Requests flow through a front register and a two-entry queue, so
// up to three requests wait while the back end is busy or stalled. Reset is
// synchronous; counts clear, credits and weights go to one, auto_add to zero.
module weighted_round_robin_pass #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 256,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wrr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wrr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  wrr_req_if.sink                            req_ch,
  wrr_res_if.source                          res_ch
);
  import wrr_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  wrr_front #(
    .NUM_QUEUES(NUM_QUEUES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  wrr_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  wrr_back #(
    .NUM_QUEUES (NUM_QUEUES),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_valid(pop_valid),
    .cmd_ready(pop_ready),
    .cmd      (pop_cmd),
    .res      (res_ch)
  );

endmodule
